FILE: rtl/banded_step_voltage_trim_loop_unit_defines.svh
// Assertion macros for the trim loop unit.
`ifndef BANDED_STEP_VOLTAGE_TRIM_LOOP_UNIT_DEFINES_SVH
`define BANDED_STEP_VOLTAGE_TRIM_LOOP_UNIT_DEFINES_SVH

// same-cycle implication
`define BSVTL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BSVTL_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/bsvtl_pkg.sv
package bsvtl_pkg;

   localparam int DAC_BITS    = 12;
   localparam int OFFSET_BITS = 18;

   localparam logic [DAC_BITS-1:0] CODE_MAX = '1;

   // shared multiplier
   localparam int MUL_W  = 28;
   localparam int PROD_W = 2 * MUL_W;

   // feed-forward datapath widths
   localparam int MAG_W   = 28;
   localparam int SQ_W    = 2 * MAG_W - 16;
   localparam int SQ_LO_W = SQ_W / 2;
   localparam int QP_W    = 36;
   localparam int QACC_W  = QP_W + SQ_LO_W + 1;
   localparam int B_W     = QACC_W - 32;
   localparam int GP_W    = 46;
   localparam int A_W     = GP_W + 1 - 16;
   localparam int SUM_W   = (OFFSET_BITS + 14 > 32) ? OFFSET_BITS + 14 : 32;
   localparam int HI_W    = SUM_W - 17;

   localparam logic [MAG_W-1:0] FF_LIN_BASE  = 28'd260835274;
   localparam logic [MUL_W-1:0] FF_LIN_SLOPE = 28'd8090;
   localparam logic [MUL_W-1:0] FF_GAIN      = 28'd66558;
   localparam logic [MUL_W-1:0] FF_QUAD      = 28'd42950;
   localparam logic signed [SUM_W-1:0] FF_BIAS = SUM_W'(425643);

   // configuration
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 2'd2;

   localparam logic [9:0] BAND_WIDTH_RESET = 10'd80;
   localparam logic [7:0] STEP_SIZE_RESET  = 8'd8;
   localparam logic [6:0] DEADBAND_RESET   = 7'd1;

   typedef struct packed {
      logic [DAC_BITS-1:0] code;
      logic                sat;
      logic                upd;
   } result_type;

endpackage

FILE: rtl/banded_step_voltage_trim_loop_unit.sv
// Voltage trim loop with banded steps. Each request word carries a target and a
// measured voltage in mV; one response word follows with the DAC code and two flags.
// A request with differing voltages reaches the response register after the five
// products that go one after another through the single 28x28 multiplier (linear
// map, square, gain, two halves of the quadratic term) and the add and clamp steps;
// a request with equal voltages goes straight from acceptance to the done state.
// req_tready is high only while the sequencer is idle, which it re-enters on the
// edge that loads the response register, so a new request is taken only after the
// last one's response has been loaded. A finished response waits in its output
// register while the next request is taken; a second finished response holds the
// sequencer until the first is taken, which lengthens the interval between requests.
// Configuration writes are taken at any time but are meant for idle periods.
`include "banded_step_voltage_trim_loop_unit_defines.svh"

module banded_step_voltage_trim_loop_unit
   import bsvtl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // target_mv[14:0], measured_mv[30:15]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // dac_code[DAC_BITS-1:0]
   output logic [1:0]            rsp_tuser    // saturated[0], updated[1]
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LIN  = 4'd1;
   localparam logic [3:0] ST_MAG  = 4'd2;
   localparam logic [3:0] ST_SQ   = 4'd3;
   localparam logic [3:0] ST_GAIN = 4'd4;
   localparam logic [3:0] ST_QLO  = 4'd5;
   localparam logic [3:0] ST_QHI  = 4'd6;
   localparam logic [3:0] ST_QSUM = 4'd7;
   localparam logic [3:0] ST_FF   = 4'd8;
   localparam logic [3:0] ST_SUM  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]                    state_ff, state_in;
   logic [9:0]                    band_width_ff;
   logic [7:0]                    step_size_ff;
   logic [6:0]                    deadband_ff;
   logic signed [OFFSET_BITS-1:0] trim_offset_ff;
   logic [DAC_BITS-1:0]           last_code_ff;

   logic [14:0]                   target_ff;
   logic [15:0]                   measured_ff;
   logic [2:0]                    steps_ff;
   logic                          neg_ff;
   logic [MAG_W-1:0]              mag_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [SQ_W-1:0]               sq_ff;
   logic signed [A_W-1:0]         a_ff;
   logic [QP_W-1:0]               qlo_ff;
   logic [B_W-1:0]                b_ff;
   logic signed [SUM_W-1:0]       ff_ff;
   result_type                    res_ff;
   logic                          rsp_valid_ff;
   result_type                    rsp_res_ff;

   logic [MUL_W-1:0]              mul_a, mul_b;
   logic                          req_fire, out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - DAC_BITS){1'b0}}, rsp_res_ff.code};
   assign rsp_tuser  = {rsp_res_ff.upd, rsp_res_ff.sat};

   // band selection
   logic [9:0]  w_eff;
   logic [15:0] err, w5, w6, w7, w8;
   logic [2:0]  steps_c;

   always_comb begin
      w_eff = (band_width_ff == 10'd0) ? 10'd1 : band_width_ff;
      w8    = {3'b0, w_eff, 3'b0};
      w7    = w8 - {6'b0, w_eff};
      w6    = {4'b0, w_eff, 2'b0} + {5'b0, w_eff, 1'b0};
      w5    = {4'b0, w_eff, 2'b0} + {6'b0, w_eff};
      err   = ({1'b0, target_ff} > measured_ff) ? {1'b0, target_ff} - measured_ff
                                                : measured_ff - {1'b0, target_ff};
      if (err < {9'b0, deadband_ff} || err > w8) begin
         steps_c = 3'd0;
      end else if (err > w7) begin
         steps_c = 3'd4;
      end else if (err > w6) begin
         steps_c = 3'd3;
      end else if (err > w5) begin
         steps_c = 3'd2;
      end else begin
         steps_c = 3'd1;
      end
   end

   // trim offset update
   logic [10:0]                   delta;
   logic signed [OFFSET_BITS:0]   off_wide;
   logic signed [OFFSET_BITS-1:0] off_next;

   always_comb begin
      case (steps_ff)
         3'd1:    delta = {3'b0, step_size_ff};
         3'd2:    delta = {2'b0, step_size_ff, 1'b0};
         3'd3:    delta = {2'b0, step_size_ff, 1'b0} + {3'b0, step_size_ff};
         3'd4:    delta = {1'b0, step_size_ff, 2'b0};
         default: delta = 11'd0;
      endcase
      if ({1'b0, target_ff} > measured_ff) begin
         off_wide = {trim_offset_ff[OFFSET_BITS-1], trim_offset_ff}
                  - $signed({{(OFFSET_BITS - 10){1'b0}}, delta});
      end else begin
         off_wide = {trim_offset_ff[OFFSET_BITS-1], trim_offset_ff}
                  + $signed({{(OFFSET_BITS - 10){1'b0}}, delta});
      end
      if (off_wide[OFFSET_BITS] != off_wide[OFFSET_BITS-1]) begin
         off_next = off_wide[OFFSET_BITS] ? {1'b1, {(OFFSET_BITS - 1){1'b0}}}
                                          : {1'b0, {(OFFSET_BITS - 1){1'b1}}};
      end else begin
         off_next = off_wide[OFFSET_BITS-1:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_LIN: begin
            mul_a = {{(MUL_W - 15){1'b0}}, target_ff};
            mul_b = FF_LIN_SLOPE;
         end
         ST_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         ST_GAIN: begin
            mul_a = mag_ff;
            mul_b = FF_GAIN;
         end
         ST_QLO: begin
            mul_a = {{(MUL_W - SQ_LO_W){1'b0}}, sq_ff[SQ_LO_W-1:0]};
            mul_b = FF_QUAD;
         end
         ST_QHI: begin
            mul_a = {{(MUL_W - (SQ_W - SQ_LO_W)){1'b0}}, sq_ff[SQ_W-1:SQ_LO_W]};
            mul_b = FF_QUAD;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath steps
   logic signed [GP_W:0]      a_full;
   logic [QACC_W-1:0]         qacc;
   logic signed [SUM_W-1:0]   ff_c, sum_c;
   logic [HI_W-1:0]           sum_hi;
   result_type                calc_res;

   always_comb begin
      a_full = neg_ff ? -$signed({1'b0, prod_ff[GP_W-1:0]})
                      : $signed({1'b0, prod_ff[GP_W-1:0]});
      qacc   = {{(QACC_W - QP_W){1'b0}}, qlo_ff}
             + {1'b0, prod_ff[QP_W-1:0], {SQ_LO_W{1'b0}}};
      ff_c   = {{(SUM_W - A_W){a_ff[A_W-1]}}, a_ff}
             - $signed({{(SUM_W - B_W){1'b0}}, b_ff}) - FF_BIAS;
      sum_c  = ff_ff + $signed({{(SUM_W - OFFSET_BITS - 12){trim_offset_ff[OFFSET_BITS-1]}},
                                trim_offset_ff, 12'b0});
      sum_hi = sum_c[SUM_W-2:16];
      calc_res.upd = 1'b1;
      if (sum_c[SUM_W-1]) begin
         calc_res.code = '0;
         calc_res.sat  = 1'b1;
      end else if ({{DAC_BITS{1'b0}}, sum_hi} > {{HI_W{1'b0}}, CODE_MAX}) begin
         calc_res.code = CODE_MAX;
         calc_res.sat  = 1'b1;
      end else begin
         calc_res.code = sum_hi[DAC_BITS-1:0];
         calc_res.sat  = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tdata[14:0] == req_tdata[30:15]) ? ST_DONE : ST_LIN;
            end
         end
         ST_LIN:  state_in = ST_MAG;
         ST_MAG:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_GAIN;
         ST_GAIN: state_in = ST_QLO;
         ST_QLO:  state_in = ST_QHI;
         ST_QHI:  state_in = ST_QSUM;
         ST_QSUM: state_in = ST_FF;
         ST_FF:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         band_width_ff  <= BAND_WIDTH_RESET;
         step_size_ff   <= STEP_SIZE_RESET;
         deadband_ff    <= DEADBAND_RESET;
         trim_offset_ff <= '0;
         last_code_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_BAND_WIDTH: band_width_ff <= csr_wdata;
               CSR_STEP_SIZE:  step_size_ff  <= csr_wdata[7:0];
               CSR_DEADBAND:   deadband_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (state_ff == ST_MAG) begin
            trim_offset_ff <= off_next;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            last_code_ff <= res_ff.code;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_fire) begin
         target_ff   <= req_tdata[14:0];
         measured_ff <= req_tdata[30:15];
         res_ff      <= '{code: last_code_ff, sat: 1'b0, upd: 1'b0};
      end
      case (state_ff)
         ST_LIN: steps_ff <= steps_c;
         ST_MAG: begin
            if (prod_ff[MAG_W-1:0] <= FF_LIN_BASE) begin
               mag_ff <= FF_LIN_BASE - prod_ff[MAG_W-1:0];
               neg_ff <= 1'b0;
            end else begin
               mag_ff <= prod_ff[MAG_W-1:0] - FF_LIN_BASE;
               neg_ff <= 1'b1;
            end
         end
         ST_GAIN: sq_ff  <= prod_ff[SQ_W+15:16];
         ST_QLO:  a_ff   <= a_full[GP_W:16];
         ST_QHI:  qlo_ff <= prod_ff[QP_W-1:0];
         ST_QSUM: b_ff   <= qacc[QACC_W-1:32];
         ST_FF:   ff_ff  <= ff_c;
         ST_SUM:  res_ff <= calc_res;
         default: ;
      endcase
      if (state_ff == ST_DONE && out_free) begin
         rsp_res_ff <= res_ff;
      end
   end

   `BSVTL_ASSERT_IMP(a_out_matches_last, clock, reset, rsp_valid_ff,
                     rsp_res_ff.code == last_code_ff)
   `BSVTL_ASSERT_IMP(a_sat_at_rail, clock, reset, rsp_valid_ff && rsp_res_ff.sat,
                     rsp_res_ff.code == '0 || rsp_res_ff.code == CODE_MAX)
   `BSVTL_ASSERT_NXT(a_trim_only_in_update, clock, reset, state_ff != ST_MAG,
                     $stable(trim_offset_ff))

endmodule
